[src/fss_pkg.sv]
// Package for the floppy stepper soft-switch block: item and result types,
// soft-switch codes and the default head travel limit. No dependencies.
`default_nettype none
package fss_pkg;

	// Default highest head position in quarter tracks
	localparam int MAX_QUARTER_TRACK = 136;

	// Soft-switch codes above the phase range
	localparam logic [3:0] SW_MOTOR_OFF   = 4'd8;
	localparam logic [3:0] SW_MOTOR_ON    = 4'd9;
	localparam logic [3:0] SW_DRIVE_ONE   = 4'd10;
	localparam logic [3:0] SW_DRIVE_TWO   = 4'd11;
	localparam logic [3:0] SW_READ_MODE   = 4'd14;

	// One bus access
	typedef struct packed {
		logic [3:0] switch_index;
		logic       is_write;
	} item_t;

	// One result
	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] head_position;
		logic       track_moved;
		logic       head_bang;
		logic       motor_running;
		logic       first_drive_selected;
		logic       unsupported;
	} res_t;

endpackage
`default_nettype wire

[src/fss_core.sv]
// Stepper state registers and the single-pass step logic for one access.
// Depends on fss_pkg.
`default_nettype none
module fss_core #(
	parameter int MAX_QUARTER_TRACK = fss_pkg::MAX_QUARTER_TRACK
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  wire fss_pkg::item_t item,
	output fss_pkg::res_t       res
);

	localparam logic [7:0] MaxPos = 8'(MAX_QUARTER_TRACK);

	logic [3:0] phase_magnets_q;
	logic [7:0] pos_q;
	logic       motor_q;
	logic       drive_q;
	logic       write_mode_q;

	logic [3:0] mag_d;
	logic [7:0] pos_d;
	logic       motor_d;
	logic       drive_d;
	logic       write_mode_d;
	logic       bang;
	logic       unsup;

	logic [1:0] phase;
	logic       turn_on;
	logic [1:0] cur_phase;
	logic       half;
	logic [1:0] diff;
	logic       cur_on;
	logic signed [2:0] delta;
	logic signed [9:0] next_pos;

	assign phase     = item.switch_index[2:1];
	assign turn_on   = item.switch_index[0];
	assign cur_phase = pos_q[2:1];
	assign half      = pos_q[0];
	assign diff      = phase - cur_phase;
	assign cur_on    = phase_magnets_q[cur_phase];

	// Head movement for a phase change, from the magnets before the access
	always_comb begin
		delta = 3'sd0;
		if (phase_magnets_q[phase] != turn_on) begin
			if (turn_on && cur_on) begin
				if (!half && diff == 2'd1) delta = 3'sd1;
				else if (!half && diff == 2'd3) delta = -3'sd1;
			end else if (turn_on) begin
				if (diff == 2'd1) delta = 3'sd2;
				else if (diff == 2'd3) delta = -3'sd2;
			end else if (cur_on) begin
				if (diff == 2'd0 && half) delta = 3'sd1;
				else if (diff == 2'd1) delta = -3'sd1;
			end
		end
	end

	assign next_pos = $signed({2'b00, pos_q}) + 10'(delta);

	// Next state and flags for the access
	always_comb begin
		mag_d        = phase_magnets_q;
		pos_d        = pos_q;
		motor_d      = motor_q;
		drive_d      = drive_q;
		write_mode_d = write_mode_q;
		bang         = 1'b0;
		unsup        = 1'b0;
		if (item.is_write) begin
			unsup = 1'b1;
		end else if (!item.switch_index[3]) begin
			mag_d[phase] = turn_on;
			if (next_pos < 10'sd0) begin
				bang  = 1'b1;
				pos_d = 8'd0;
			end else if (next_pos > $signed({2'b00, MaxPos})) begin
				pos_d = MaxPos;
			end else begin
				pos_d = next_pos[7:0];
			end
		end else begin
			case (item.switch_index)
				fss_pkg::SW_MOTOR_OFF: motor_d      = 1'b0;
				fss_pkg::SW_MOTOR_ON:  motor_d      = 1'b1;
				fss_pkg::SW_DRIVE_ONE: drive_d      = 1'b1;
				fss_pkg::SW_DRIVE_TWO: drive_d      = 1'b0;
				fss_pkg::SW_READ_MODE: write_mode_d = 1'b0;
				default:               unsup        = 1'b1;
			endcase
		end
	end

	// Result as seen after the access
	always_comb begin
		res.read_data            = 8'd0;
		res.head_position        = pos_d;
		res.track_moved          = (pos_d != pos_q);
		res.head_bang            = bang;
		res.motor_running        = motor_d;
		res.first_drive_selected = drive_d;
		res.unsupported          = unsup;
	end

	// Stepper state, updated once per access leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_magnets_q <= 4'd0;
			pos_q           <= 8'd0;
			motor_q         <= 1'b0;
			drive_q         <= 1'b0;
			write_mode_q    <= 1'b0;
		end else if (step_en) begin
			phase_magnets_q <= mag_d;
			pos_q           <= pos_d;
			motor_q         <= motor_d;
			drive_q         <= drive_d;
			write_mode_q    <= write_mode_d;
		end
	end

endmodule
`default_nettype wire

[src/floppy_stepper_soft_switches.sv]
// Top level of the floppy stepper soft-switch block: input stage, step core
// and result register. Depends on fss_pkg and fss_core.
//
// Each access transferred on req is registered in the input stage, decoded
// against the stepper state by fss_core and placed in the result register,
// from which it shows on rsp and transfers when rsp_ready is high.
// One access per cycle is taken as long as rsp is taken; the stepper state
// in fss_core is updated as each access leaves the input stage. A stalled
// result holds while one more access waits in the input stage, after which
// req_ready drops. MAX_QUARTER_TRACK sets the top clamp.
`default_nettype none
module floppy_stepper_soft_switches #(
	parameter int MAX_QUARTER_TRACK = fss_pkg::MAX_QUARTER_TRACK
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [3:0] switch_index,
	input  wire logic       is_write,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [7:0]      read_data,
	output logic [7:0]      head_position,
	output logic            track_moved,
	output logic            head_bang,
	output logic            motor_running,
	output logic            first_drive_selected,
	output logic            unsupported
);

	logic           valid_s1;
	fss_pkg::item_t item_s1;
	logic           valid_s2;
	fss_pkg::res_t  res_s2;
	fss_pkg::res_t  res_c;
	logic           advance;

	// Stage 1 moves on when the result register is free or being drained
	assign advance   = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	fss_core #(
		.MAX_QUARTER_TRACK(MAX_QUARTER_TRACK)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(valid_s1 && advance),
		.item   (item_s1),
		.res    (res_c)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) valid_s1 <= req_valid;
			if (advance)   valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1.switch_index <= switch_index;
			item_s1.is_write     <= is_write;
		end
		if (advance && valid_s1) res_s2 <= res_c;
	end

	assign rsp_valid            = valid_s2;
	assign read_data            = res_s2.read_data;
	assign head_position        = res_s2.head_position;
	assign track_moved          = res_s2.track_moved;
	assign head_bang            = res_s2.head_bang;
	assign motor_running        = res_s2.motor_running;
	assign first_drive_selected = res_s2.first_drive_selected;
	assign unsupported          = res_s2.unsupported;

endmodule
`default_nettype wire

[src/fss_checker.sv]
// Port-level checks for floppy_stepper_soft_switches and the bind that
// attaches them. Depends on fss_pkg.
`default_nettype none
module fss_checker #(
	parameter int MAX_QUARTER_TRACK = fss_pkg::MAX_QUARTER_TRACK
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] read_data,
	input wire logic [7:0] head_position,
	input wire logic       track_moved,
	input wire logic       head_bang,
	input wire logic       unsupported
);

	// A stalled result holds its head position and bang flag
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(head_position) && $stable(head_bang))
		else $error("rsp changed while stalled");

	// Head never passes the top clamp
	a_pos_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> head_position <= 8'(MAX_QUARTER_TRACK))
		else $error("head beyond top track");

	// A bang leaves the head on track zero
	a_bang_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && head_bang |-> head_position == 8'd0)
		else $error("bang away from track zero");

	// Unsupported accesses never move the head or bang, and read as zero
	a_unsup_still: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && unsupported |-> !track_moved && !head_bang && read_data == 8'd0)
		else $error("unsupported access changed head");

endmodule

bind floppy_stepper_soft_switches fss_checker #(
	.MAX_QUARTER_TRACK(MAX_QUARTER_TRACK)
) u_fss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_ready    (rsp_ready),
	.read_data    (read_data),
	.head_position(head_position),
	.track_moved  (track_moved),
	.head_bang    (head_bang),
	.unsupported  (unsupported)
);
`default_nettype wire
